// ----- hw/rtl/brrs_pkg.sv -----
// shared types and constants for the burst round-robin scheduler
`timescale 1ns / 1ps

package brrs_pkg;

    localparam int PORTS  = 16;
    localparam int PORT_W = 4;
    localparam int ACT_W  = 5;
    localparam int CNT_W  = 16;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [0:0] {
        REG_BURST_LEN    = 1'b0,
        REG_ACTIVE_PORTS = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic              found;
        logic [PORT_W-1:0] port;
        logic              at_start;
    } pick_t;

endpackage

// ----- hw/rtl/burst_round_robin_scheduler_unit.sv -----
// top level of the burst round-robin scheduler
`timescale 1ns / 1ps

// Each request on the slave stream carries a 16-bit ready mask and yields one
// result on the master stream: a granted flag and the granted port. The scan
// starts at the stored next port, wraps within the active ports and grants
// the first ready one; a port keeps the grant for burst_len requests in a row
// unless a scan has to skip past an empty port, which restarts its count.
// A request is taken into an input register, resolved by one rotating
// priority encoder plus a 16-bit count compare, and written to the result
// register, so one request is accepted every cycle unless the master stream
// stalls; the next port and burst count are updated as each result is
// registered, which sets that rate. Write burst_len and active_ports only
// while no request is in flight.
module burst_round_robin_scheduler_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [brrs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [15:0] ready_mask
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [brrs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [0] granted, [4:1] grant_port
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_addr,
    input  logic [brrs_pkg::CNT_W-1:0]          cfg_wdata
);
    import brrs_pkg::*;

    logic [CNT_W-1:0]  burst_len_reg;
    logic [ACT_W-1:0]  active_ports_reg;
    logic [PORT_W-1:0] next_port_reg;
    logic [PORT_W-1:0] next_port_next;
    logic [CNT_W-1:0]  burst_count_reg;
    logic [CNT_W-1:0]  burst_count_next;

    logic              in_valid_reg;
    logic [PORTS-1:0]  in_mask_reg;
    logic              out_valid_reg;
    logic              out_granted_reg;
    logic [PORT_W-1:0] out_port_reg;

    logic              advance;
    logic [ACT_W-1:0]  act_eff;
    logic [PORT_W-1:0] start;
    pick_t             pick;
    logic [CNT_W-1:0]  cnt_inc;
    logic [ACT_W-1:0]  port_plus;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // clamp the active count to 1..PORTS
    always_comb
    begin
        if (active_ports_reg == '0)
        begin
            act_eff = ACT_W'(1);
        end
        else if (active_ports_reg > ACT_W'(PORTS))
        begin
            act_eff = ACT_W'(PORTS);
        end
        else
        begin
            act_eff = active_ports_reg;
        end
    end

    assign start = ({1'b0, next_port_reg} < act_eff) ? next_port_reg : '0;

    brrs_pick u_pick (
        .ready_mask (in_mask_reg),
        .start      (start),
        .act        (act_eff),
        .pick       (pick)
    );

    // a skipped port restarts the count
    assign cnt_inc   = (pick.at_start ? burst_count_reg : '0) + CNT_W'(1);
    assign port_plus = {1'b0, pick.port} + ACT_W'(1);

    always_comb
    begin
        next_port_next   = next_port_reg;
        burst_count_next = '0;
        if (pick.found)
        begin
            if (cnt_inc == burst_len_reg)
            begin
                next_port_next = (port_plus >= act_eff) ? '0 : port_plus[PORT_W-1:0];
            end
            else
            begin
                next_port_next   = pick.port;
                burst_count_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_len_reg    <= CNT_W'(1);
            active_ports_reg <= ACT_W'(PORTS);
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_BURST_LEN:    burst_len_reg    <= cfg_wdata;
                REG_ACTIVE_PORTS: active_ports_reg <= cfg_wdata[ACT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            next_port_reg   <= '0;
            burst_count_reg <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                next_port_reg   <= next_port_next;
                burst_count_reg <= burst_count_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_mask_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_granted_reg <= pick.found;
            out_port_reg    <= pick.found ? pick.port : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - PORT_W - 1)'(0), out_port_reg, out_granted_reg};

endmodule

// ----- hw/rtl/brrs_pick.sv -----
// rotating priority encoder over the ports taking part in the rotation
`timescale 1ns / 1ps

module brrs_pick (
    input  logic [brrs_pkg::PORTS-1:0]  ready_mask,
    input  logic [brrs_pkg::PORT_W-1:0] start,
    input  logic [brrs_pkg::ACT_W-1:0]  act,
    output brrs_pkg::pick_t             pick
);
    import brrs_pkg::*;

    logic [PORTS-1:0]  in_rot;
    logic [PORTS-1:0]  upper;
    logic [PORTS-1:0]  cand;
    logic [PORT_W-1:0] low_idx;

    // ports at or above the active count never win
    always_comb
    begin
        for (int i = 0; i < PORTS; i++)
        begin
            in_rot[i] = ready_mask[i] && (ACT_W'(i) < act);
            upper[i]  = in_rot[i] && (PORT_W'(i) >= start);
        end
    end

    // wrap to the low ports when nothing at or above start is ready
    assign cand = (|upper) ? upper : in_rot;

    always_comb
    begin
        low_idx = '0;
        for (int i = PORTS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                low_idx = PORT_W'(i);
            end
        end
    end

    assign pick.found    = |in_rot;
    assign pick.port     = low_idx;
    assign pick.at_start = (low_idx == start);

endmodule

// ----- dv/burst_round_robin_scheduler_unit_tb.sv -----
// testbench for the burst round-robin scheduler against a local scheduler model
`timescale 1ns / 1ps

module burst_round_robin_scheduler_unit_tb;

    import brrs_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 94;

    typedef struct packed {
        logic              granted;
        logic [PORT_W-1:0] port;
    } grant_t;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;    // [15:0] ready_mask
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // [0] granted, [4:1] grant_port
    logic                   cfg_we        = 1'b0;
    logic [0:0]             cfg_addr      = '0;
    logic [CNT_W-1:0]       cfg_wdata     = '0;

    // scheduler model state and its copy of the registers
    logic [CNT_W-1:0]  cfg_burst_len   = 16'd1;
    logic [ACT_W-1:0]  cfg_active      = 5'd16;
    logic [PORT_W-1:0] sched_next_port = '0;
    logic [CNT_W-1:0]  sched_burst_cnt = '0;

    logic [IN_TDATA_W-1:0] mask_q[$];
    grant_t                grant_q[$];

    logic        req_fire     = 1'b0;
    int          err_count    = 0;
    int          stuck_cycles = 0;
    int          src_burst_left = 1;
    int          src_gap_left   = 0;
    logic        drain_hold     = 1'b0;
    logic [15:0] rx_pat         = '1;
    int          rx_age         = 0;

    int phase_burst[PHASES]  = '{1, 65535, 0, 2, 3, 100, 4, 1, 7, 65535, 0, 0};
    int phase_active[PHASES] = '{16, 31, 16, 4, 1, 2, 8, 15, 35, 3, 0, 0};

    burst_round_robin_scheduler_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int eff_ports();
        int act;
        act = int'(cfg_active);
        if (act == 0)
            act = 1;
        if (act > PORTS)
            act = PORTS;
        return act;
    endfunction

    function automatic grant_t next_grant(logic [IN_TDATA_W-1:0] mask);
        int     act;
        int     p;
        int     nxt;
        grant_t g;
        act = eff_ports();
        p   = (int'(sched_next_port) >= act) ? 0 : int'(sched_next_port);
        g   = '0;
        for (int j = 0; j < act; j++)
        begin
            if (mask[p])
            begin
                sched_burst_cnt = sched_burst_cnt + 16'd1;
                nxt = p;
                if (sched_burst_cnt == cfg_burst_len)
                begin
                    nxt = (p + 1 >= act) ? 0 : p + 1;
                    sched_burst_cnt = '0;
                end
                sched_next_port = nxt[PORT_W-1:0];
                g.granted = 1'b1;
                g.port    = p[PORT_W-1:0];
                return g;
            end
            p = (p + 1 >= act) ? 0 : p + 1;
            sched_burst_cnt = '0;
        end
        sched_burst_cnt = '0;
        return g;
    endfunction

    task automatic note_error(string msg);
        err_count++;
        if (err_count <= 10)
            $display("%s", msg);
    endtask

    // driver: sender bursts and gaps, receiver stall pattern
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_age == 0)
            begin
                rx_age = $urandom_range(20, 120);
                case ($urandom_range(0, 3))
                    0: rx_pat = '1;
                    1: rx_pat = 16'($urandom) | 16'h1;
                    2: rx_pat = 16'($urandom | $urandom);
                    default: rx_pat = 16'($urandom & $urandom) | 16'h1;
                endcase
            end
            rx_age--;
            rx_pat = {rx_pat[14:0], rx_pat[15]};
            m_axis_tready <= rx_pat[0];

            if (!s_axis_tvalid || req_fire)
            begin
                if (src_gap_left > 0)
                begin
                    src_gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (drain_hold && grant_q.size() != 0)
                    s_axis_tvalid <= 1'b0;
                else if (mask_q.size() != 0)
                begin
                    drain_hold = 1'b0;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= mask_q.pop_front();
                    if (src_burst_left > 1)
                        src_burst_left--;
                    else
                    begin
                        src_burst_left = ($urandom_range(0, 7) == 0) ?
                            $urandom_range(100, 300) : $urandom_range(1, 30);
                        src_gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                        // now and then hold off until every grant is back
                        drain_hold = ($urandom_range(0, 24) == 0);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: predicts on each accepted request, checks each accepted result
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n)
        begin
            req_fire <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (grant_q.size() == 0)
                    note_error($sformatf("ERROR: unexpected result granted=%0d port=%0d",
                                         m_axis_tdata[0], m_axis_tdata[4:1]));
                else
                begin
                    want = grant_q.pop_front();
                    if (m_axis_tdata[0] !== want.granted)
                        note_error($sformatf("ERROR: granted expected %0d got %0d",
                                             want.granted, m_axis_tdata[0]));
                    if (m_axis_tdata[4:1] !== want.port)
                        note_error($sformatf("ERROR: grant_port expected %0d got %0d",
                                             want.port, m_axis_tdata[4:1]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                grant_q.push_back(next_grant(s_axis_tdata));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("timeout: no request moved for %0d cycles", STUCK_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (mask_q.size() != 0 || s_axis_tvalid || grant_q.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CNT_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_BURST_LEN)
            cfg_burst_len = val;
        else
            cfg_active = val[ACT_W-1:0];
    endtask

    task automatic queue_random_runs(int n);
        logic [15:0] m;
        logic [15:0] in_rot;
        int          run;
        int          left;
        left   = n;
        in_rot = 16'hFFFF >> (16 - eff_ports());
        while (left > 0)
        begin
            case ($urandom_range(0, 8))
                0: m = '1;
                1: m = '0;
                2: m = 16'h1 << $urandom_range(0, 15);
                3: m = 16'($urandom);
                4: m = 16'($urandom & $urandom);
                5: m = 16'($urandom | $urandom);
                6: m = 16'($urandom) & in_rot;
                7: m = 16'h3 << $urandom_range(0, 14);
                default: m = ~in_rot | (16'($urandom & $urandom) & in_rot);
            endcase
            run = $urandom_range(1, 12);
            for (int k = 0; k < run && left > 0; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    m = m ^ (16'h1 << $urandom_range(0, 15));
                mask_q.push_back(m);
                left--;
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: burst of one over all sixteen ports
        mask_q = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h8000,
                   16'h8001, 16'hAAAA, 16'h5555, 16'h4000};
        wait_idle();

        // next port left beyond the shrunk rotation, ready bits outside it
        write_reg(REG_ACTIVE_PORTS, 16'd5);
        write_reg(REG_BURST_LEN, 16'd3);
        mask_q = '{16'h001F, 16'h001F, 16'h001F, 16'h001F, 16'h0002,
                   16'hFFE0, 16'h0010, 16'h0010, 16'h0010, 16'h0001};
        wait_idle();

        // zero active ports acts as one, oversized value acts as all
        write_reg(REG_ACTIVE_PORTS, 16'd0);
        mask_q = '{16'h0001, 16'hFFFE, 16'h0003};
        wait_idle();
        write_reg(REG_ACTIVE_PORTS, 16'd17);
        mask_q = '{16'hFFFF, 16'h8000};

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            if (ph >= 10)
            begin
                write_reg(REG_BURST_LEN, 16'($urandom_range(1, 12)));
                write_reg(REG_ACTIVE_PORTS, 16'($urandom));
            end
            else
            begin
                write_reg(REG_BURST_LEN, 16'(phase_burst[ph]));
                write_reg(REG_ACTIVE_PORTS, 16'(phase_active[ph]));
            end
            queue_random_runs(PHASE_ITEMS);
        end

        wait_idle();
        repeat (5) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
